>>> design/wgm_pkg.sv
// Shared types and constants for the wildcard glob matcher.
package wgm_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_NAME_BYTE = 2'd2;
    localparam logic [1:0] OP_EMPTY_NAME = 2'd3;

    localparam logic [7:0] STAR_CODE = 8'h2A;
    localparam logic [7:0] QMARK_CODE = 8'h3F;
    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_Z = 8'h7A;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_code;
        logic       last;
    } wgm_in_t;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } wgm_out_t;

    typedef enum logic [2:0] {
        CMD_CLEAR,
        CMD_APPEND,
        CMD_BYTE,
        CMD_END_EMPTY,
        CMD_END
    } wgm_cmd_kind_t;

    typedef struct packed {
        wgm_cmd_kind_t kind;
        logic [7:0]    char_code;
        logic          last;
    } wgm_cmd_t;

endpackage

>>> design/wildcard_glob_matcher_top.sv
// Top level of the wildcard glob matcher: front end, command queue, match engine.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_ready   in_data  (opcode, char_code, last)
//   out      output     out_valid/out_ready out_data (matched, pattern_overflow)
//
// One item per cycle is sustained while out_ready stays high; the engine then
// executes one command per cycle and registers each result in the output register.
// An input transfer lands in a queue slot at its accepting edge; the engine takes
// it from the queue head and registers its result, which raises out_valid.
// Reset leaves an empty pattern with only position zero live.
// While a result waits on out_ready the engine holds; the two-entry queue
// then fills and drops in_ready.
module wildcard_glob_matcher_top #(
    parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  wgm_pkg::wgm_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output wgm_pkg::wgm_out_t out_data
);
    import wgm_pkg::*;

    wgm_cmd_t front_cmd;
    logic     front_keep;
    logic     q_space;
    logic     q_push;
    logic     q_head_valid;
    wgm_cmd_t q_head_cmd;
    logic     q_pop;

    assign in_ready = q_space;
    assign q_push = in_valid && q_space && front_keep;

    wgm_front u_front (
        .in_data (in_data),
        .keep    (front_keep),
        .cmd     (front_cmd)
    );

    wgm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (front_cmd),
        .space      (q_space),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .pop        (q_pop)
    );

    wgm_engine #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_head_valid),
        .cmd       (q_head_cmd),
        .cmd_pop   (q_pop),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res_data  (out_data)
    );

endmodule

>>> design/wgm_front.sv
// Front end: takes input transfers and turns them into engine commands.
module wgm_front (
    input  wgm_pkg::wgm_in_t  in_data,
    output logic              keep,
    output wgm_pkg::wgm_cmd_t cmd
);
    import wgm_pkg::*;

    always_comb
    begin
        cmd.char_code = in_data.char_code;
        cmd.last = in_data.last;
        cmd.kind = CMD_CLEAR;
        keep = 1'b1;
        case (in_data.opcode)
            OP_CLEAR:
            begin
                cmd.kind = CMD_CLEAR;
            end
            OP_APPEND:
            begin
                cmd.kind = CMD_APPEND;
                keep = (in_data.char_code != 8'd0);
            end
            OP_NAME_BYTE:
            begin
                // a zero byte is not consumed, but may still end the name
                if (in_data.char_code != 8'd0)
                begin
                    cmd.kind = CMD_BYTE;
                end
                else
                begin
                    cmd.kind = CMD_END;
                    keep = in_data.last;
                end
            end
            OP_EMPTY_NAME:
            begin
                cmd.kind = CMD_END_EMPTY;
            end
            default:
            begin
                cmd.kind = CMD_CLEAR;
            end
        endcase
    end

endmodule

>>> design/wgm_queue.sv
// Two-entry command queue between the front end and the match engine.
module wgm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wgm_pkg::wgm_cmd_t push_cmd,
    output logic              space,
    output logic              head_valid,
    output wgm_pkg::wgm_cmd_t head_cmd,
    input  logic              pop
);
    import wgm_pkg::*;

    wgm_cmd_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   count_reg;
    logic [QUEUE_CNT_W-1:0]   count_next;

    assign space = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> design/wgm_engine.sv
// Match engine: pattern storage, active position set and result register.
module wgm_engine #(
    parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  wgm_pkg::wgm_cmd_t cmd,
    output logic              cmd_pop,
    output logic              res_valid,
    input  logic              res_ready,
    output wgm_pkg::wgm_out_t res_data
);
    import wgm_pkg::*;

    localparam int N = MAX_PATTERN;
    localparam int LW = $clog2(N + 1);
    localparam int IW = (N > 1) ? $clog2(N) : 1;

    // Star closure as a carry chain: stars propagate, live stars generate.
    function automatic logic [N:0] star_close(input logic [N:0] seed,
                                              input logic [N-1:0] star);
        logic [N:0] s;
        logic [N:0] g;
        logic [N:0] c;
        s = {1'b0, star};
        g = seed & s;
        c = (g + s) ^ g ^ s;
        return seed | c;
    endfunction

    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        return (c >= LOWER_A && c <= LOWER_Z) ? (c - 8'h20) : c;
    endfunction

    logic [7:0]    char_reg [N];
    logic [N-1:0]  star_reg;
    logic [N-1:0]  star_next;
    logic [N-1:0]  qmark_reg;
    logic [N-1:0]  qmark_next;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic [N:0]    init_reg;
    logic [N:0]    init_next;
    logic [N:0]    act_reg;
    logic [N:0]    act_next;
    logic          res_valid_reg;
    logic          res_valid_next;
    wgm_out_t      res_reg;
    wgm_out_t      res_next;

    logic [7:0]    fold_c;
    logic [N:0]    keep_v;
    logic [N:0]    move_v;
    logic [N:0]    adv_v;
    logic          full;
    logic          store_wr;
    logic [IW-1:0] wr_idx;
    logic [N-1:0]  star_app;
    logic [N-1:0]  qmark_app;

    assign cmd_pop = cmd_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res_data = res_reg;

    assign fold_c = fold_byte(cmd.char_code);
    assign full = (len_reg == LW'(N));
    assign wr_idx = len_reg[IW-1:0];

    always_comb
    begin
        keep_v = '0;
        move_v = '0;
        for (int i = 0; i < N; i++)
        begin
            if (act_reg[i] && (LW'(i) < len_reg))
            begin
                if (star_reg[i])
                begin
                    keep_v[i] = 1'b1;
                end
                else if (qmark_reg[i] || (char_reg[i] == fold_c))
                begin
                    move_v[i+1] = 1'b1;
                end
            end
        end
        adv_v = star_close(keep_v | move_v, star_reg);
    end

    always_comb
    begin
        star_app = star_reg;
        qmark_app = qmark_reg;
        star_app[wr_idx] = (cmd.char_code == STAR_CODE);
        qmark_app[wr_idx] = (cmd.char_code == QMARK_CODE);
    end

    always_comb
    begin
        star_next = star_reg;
        qmark_next = qmark_reg;
        len_next = len_reg;
        ovf_next = ovf_reg;
        init_next = init_reg;
        act_next = act_reg;
        store_wr = 1'b0;
        res_next = res_reg;
        res_valid_next = res_valid_reg && !res_ready;
        if (cmd_pop)
        begin
            case (cmd.kind)
                CMD_CLEAR:
                begin
                    star_next = '0;
                    qmark_next = '0;
                    len_next = '0;
                    ovf_next = 1'b0;
                    init_next = (N + 1)'(1);
                    act_next = (N + 1)'(1);
                end
                CMD_APPEND:
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                        act_next = init_reg;
                    end
                    else
                    begin
                        store_wr = 1'b1;
                        star_next = star_app;
                        qmark_next = qmark_app;
                        len_next = len_reg + 1'b1;
                        init_next = star_close((N + 1)'(1), star_app);
                        act_next = init_next;
                    end
                end
                CMD_BYTE:
                begin
                    if (cmd.last)
                    begin
                        res_valid_next = 1'b1;
                        res_next.matched = adv_v[len_reg];
                        res_next.pattern_overflow = ovf_reg;
                        act_next = init_reg;
                    end
                    else
                    begin
                        act_next = adv_v;
                    end
                end
                CMD_END_EMPTY:
                begin
                    res_valid_next = 1'b1;
                    res_next.matched = init_reg[len_reg];
                    res_next.pattern_overflow = ovf_reg;
                    act_next = init_reg;
                end
                CMD_END:
                begin
                    res_valid_next = 1'b1;
                    res_next.matched = act_reg[len_reg];
                    res_next.pattern_overflow = ovf_reg;
                    act_next = init_reg;
                end
                default:
                begin
                    act_next = act_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            star_reg <= '0;
            qmark_reg <= '0;
            len_reg <= '0;
            ovf_reg <= 1'b0;
            init_reg <= (N + 1)'(1);
            act_reg <= (N + 1)'(1);
            res_valid_reg <= 1'b0;
            res_reg <= '0;
        end
        else
        begin
            star_reg <= star_next;
            qmark_reg <= qmark_next;
            len_reg <= len_next;
            ovf_reg <= ovf_next;
            init_reg <= init_next;
            act_reg <= act_next;
            res_valid_reg <= res_valid_next;
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            char_reg[wr_idx] <= fold_byte(cmd.char_code);
        end
    end

endmodule
